[src/thl_pkg.sv]
`timescale 1ns / 1ps

package thl_pkg;

   localparam int NUM_POINTS  = 22;
   localparam int ADC_W       = 10;
   localparam int IDX_W       = $clog2(NUM_POINTS);
   localparam int CEL_W       = 10;
   localparam int DUTY_W      = 8;
   localparam int TEMP_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   // |(s - A[k-1]) * rise| peaks at 58 * 432 on the first segment; 15 bits hold it
   localparam int MAG_W = 15;
   localparam int CNT_W = $clog2(MAG_W);

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_TEMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEATER_POWER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_SPEED   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_FORWARD = 2'd3;

   localparam logic [ADC_W-1:0] BP_ADC [NUM_POINTS] = '{
      10'd1,   10'd60,  10'd70,  10'd80,  10'd90,  10'd100, 10'd110, 10'd120,
      10'd130, 10'd140, 10'd150, 10'd160, 10'd170, 10'd180, 10'd190, 10'd200,
      10'd210, 10'd220, 10'd230, 10'd240, 10'd250, 10'd300
   };

   localparam logic [CEL_W-1:0] BP_CEL [NUM_POINTS] = '{
      10'd608, 10'd176, 10'd166, 10'd157, 10'd150, 10'd143, 10'd137, 10'd131,
      10'd125, 10'd120, 10'd115, 10'd110, 10'd105, 10'd100, 10'd95,  10'd91,
      10'd86,  10'd81,  10'd75,  10'd70,  10'd64,  10'd4
   };

   typedef struct packed {
      logic [ADC_W-1:0] sample;
      logic [IDX_W-1:0] seg;
      logic             hit;
   } thl_seg_type;

   typedef struct packed {
      logic [TEMP_W-1:0] target_temp;
      logic [DUTY_W-1:0] heater_power;
      logic [DUTY_W-1:0] motor_speed;
      logic              motor_forward;
   } thl_cfg_type;

endpackage

[src/thl_front.sv]
`timescale 1ns / 1ps

module thl_front import thl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // [9:0] adc_sample
   output logic             push_valid,
   input  logic             push_ready,
   output thl_seg_type      push_data
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_WALK = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type  state_ff, state_in;
   logic [ADC_W-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0] seg_ff, seg_in;
   logic             hit_ff, hit_in;

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      seg_in    = seg_ff;
      hit_in    = hit_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[ADC_W-1:0];
               seg_in    = IDX_W'(1);
               state_in  = F_WALK;
            end
         end
         F_WALK: begin
            // one breakpoint per cycle
            if (BP_ADC[seg_ff] > sample_ff) begin
               hit_in   = 1'b1;
               state_in = F_PUSH;
            end else if (seg_ff == IDX_W'(NUM_POINTS - 1)) begin
               hit_in   = 1'b0;
               state_in = F_PUSH;
            end else begin
               seg_in = seg_ff + IDX_W'(1);
            end
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sample_ff <= sample_in;
      seg_ff    <= seg_in;
      hit_ff    <= hit_in;
   end

   assign req_tready       = (state_ff == F_IDLE);
   assign push_valid       = (state_ff == F_PUSH);
   assign push_data.sample = sample_ff;
   assign push_data.seg    = seg_ff;
   assign push_data.hit    = hit_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_WALK) |-> (seg_ff >= IDX_W'(1) && seg_ff <= IDX_W'(NUM_POINTS - 1)))
      else $error("walk index out of table");

endmodule

[src/thl_queue.sv]
`timescale 1ns / 1ps

module thl_queue import thl_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  thl_seg_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output thl_seg_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   thl_seg_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

endmodule

[src/thl_back.sv]
`timescale 1ns / 1ps

module thl_back import thl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  thl_seg_type pop_data,
   input  thl_cfg_type cfg,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] temperature_c, [15:8] motor_drive,
                                    // [23:16] heater_drive, [24] direction_out
);

   localparam int DIFF_W = ADC_W + 1;
   localparam int RISE_W = CEL_W + 1;
   localparam int PROD_W = DIFF_W + RISE_W;
   localparam int SUM_W  = MAG_W + 2;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_MUL  = 4'b0010,
      B_DIV  = 4'b0100,
      B_FIN  = 4'b1000
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic                      hit_ff, hit_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [RISE_W-1:0]  rise_ff, rise_in;
   logic [ADC_W-1:0]          span_ff, span_in;
   logic [CEL_W-1:0]          base_ff, base_in;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          dq_ff, dq_in;
   logic [ADC_W-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]          seg_prev;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_abs;
   logic [ADC_W:0]            trial;
   logic                      ge;
   logic signed [SUM_W-1:0]   q_ext;
   logic signed [SUM_W-1:0]   sum;
   logic [TEMP_W-1:0]         temp;
   logic [ADC_W-1:0]          span_raw;
   logic                      slot_free;

   assign seg_prev  = pop_data.seg - IDX_W'(1);
   assign span_raw  = BP_ADC[pop_data.seg] - BP_ADC[seg_prev];
   assign prod      = diff_ff * rise_ff;
   assign prod_abs  = prod[PROD_W-1] ? -prod : prod;
   assign trial     = {rem_ff, dq_ff[MAG_W-1]};
   assign ge        = (trial >= {1'b0, span_ff});
   assign q_ext     = $signed({2'b00, dq_ff});
   assign sum       = $signed({{(SUM_W - CEL_W){1'b0}}, base_ff}) + (neg_ff ? -q_ext : q_ext);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == B_IDLE);

   // clamp to 0..255; off the end of the table reads as 0
   always_comb begin
      if (!hit_ff || sum[SUM_W-1]) begin
         temp = '0;
      end else if (sum > SUM_W'(255)) begin
         temp = '1;
      end else begin
         temp = sum[TEMP_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      diff_in      = diff_ff;
      rise_in      = rise_ff;
      span_in      = span_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               hit_in  = pop_data.hit;
               diff_in = $signed({1'b0, pop_data.sample}) - $signed({1'b0, BP_ADC[seg_prev]});
               rise_in = $signed({1'b0, BP_CEL[pop_data.seg]})
                       - $signed({1'b0, BP_CEL[seg_prev]});
               span_in = (span_raw == '0) ? ADC_W'(1) : span_raw;
               base_in = BP_CEL[seg_prev];
               state_in = pop_data.hit ? B_MUL : B_FIN;
            end
         end
         B_MUL: begin
            neg_in   = prod[PROD_W-1];
            dq_in    = prod_abs[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = CNT_W'(MAG_W - 1);
            state_in = B_DIV;
         end
         B_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = ge ? ADC_W'(trial - {1'b0, span_ff}) : trial[ADC_W-1:0];
            dq_in  = {dq_ff[MAG_W-2:0], ge};
            if (cnt_ff == '0) begin
               state_in = B_FIN;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         B_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[7:0] = temp;
               if (temp < cfg.target_temp) begin
                  rsp_data_in[23:16] = cfg.heater_power;
               end else begin
                  rsp_data_in[15:8] = cfg.motor_speed;
               end
               rsp_data_in[24] = cfg.motor_forward;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff      <= hit_in;
      diff_ff     <= diff_in;
      rise_ff     <= rise_in;
      span_ff     <= span_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && cnt_ff == '0) |=> (state_ff == B_FIN))
      else $error("divider did not finish");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == B_MUL || state_ff == B_FIN))
      else $error("popped word not started");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FIN && slot_free) |=> rsp_valid_ff)
      else $error("finished word not loaded");

endmodule

[src/thermistor_lookup_heater_control.sv]
`timescale 1ns / 1ps

// Thermistor lookup and bang-bang heater control. Each req word carries one
// 10-bit converter sample; one rsp word comes back with the temperature in
// Celsius (linear interpolation over a 22-point breakpoint table, clamped to
// 255, 0 at or past the last breakpoint) and the motor and heater duties:
// below target_temp the heater gets heater_power and the motor 0, otherwise
// the motor gets motor_speed and the heater 0; direction_out follows
// motor_forward. The front end walks the table one breakpoint per cycle
// (1 to 21 breakpoints) and takes no new sample until it has pushed the
// last one on; the back end loads, multiplies, runs a serial divide over
// the 15-bit quotient and finishes, or loads and finishes past the table,
// and takes no new word until it has finished the last. A queue between
// the two lets them overlap, so the sustained rate is set by the slower of
// the table walk and the divider. Configuration writes take effect at once and belong in idle periods.

module thermistor_lookup_heater_control import thl_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [9:0] adc_sample
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [7:0] temperature_c, [15:8] motor_drive,
                                             // [23:16] heater_drive, [24] direction_out
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   thl_cfg_type cfg_ff, cfg_in;
   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;
   thl_seg_type push_data, pop_data;

   // register file; every index in range maps to a register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TARGET_TEMP:   cfg_in.target_temp   = csr_wdata;
            REG_HEATER_POWER:  cfg_in.heater_power  = csr_wdata;
            REG_MOTOR_SPEED:   cfg_in.motor_speed   = csr_wdata;
            REG_MOTOR_FORWARD: cfg_in.motor_forward = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp   <= '0;
         cfg_ff.heater_power  <= '0;
         cfg_ff.motor_speed   <= '0;
         cfg_ff.motor_forward <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept sample, walk the table to find its segment
   thl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // segment queue between front and back
   thl_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: interpolate, divide, clamp, decide drives, hold result
   thl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/thermistor_lookup_heater_control_test.sv]
`timescale 1ns / 1ps

// Testbench for the thermistor lookup and bang-bang heater control block.
// Samples go in on the req stream, one result word per sample comes back
// on the rsp stream. A local model of the breakpoint table and of the
// heater/motor decision predicts every result at the moment its sample is
// accepted; a checker compares each result word field by field with the
// oldest prediction. Both sides idle at random, one test holds the result
// side off long enough to back the block up, and register settings change
// only between phases once all results are home.

module thermistor_lookup_heater_control_test;
   import thl_pkg::*;

   localparam int STALL_LIMIT = 3000;   // cycles with no word moving on either side
   localparam int TAIL_CYCLES = 60;     // cycles to idle after the last result is home

   typedef struct {
      logic [15:0] sample_word;
      logic [7:0]  temperature_c;
      logic [7:0]  motor_drive;
      logic [7:0]  heater_drive;
      logic        direction_out;
   } drive_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // [9:0] adc_sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;         // [7:0] temperature_c, [15:8] motor_drive,
                                            // [23:16] heater_drive, [24] direction_out
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [7:0]           csr_wdata  = '0;

   // thermistor curve: converter reading and Celsius at each breakpoint
   int knee_adc [22] = '{  1,  60,  70,  80,  90, 100, 110, 120, 130, 140, 150,
                         160, 170, 180, 190, 200, 210, 220, 230, 240, 250, 300};
   int knee_cel [22] = '{608, 176, 166, 157, 150, 143, 137, 131, 125, 120, 115,
                         110, 105, 100,  95,  91,  86,  81,  75,  70,  64,   4};

   // shadow copy of the control registers
   logic [7:0] target_temp   = 8'd0;
   logic [7:0] heater_power  = 8'd0;
   logic [7:0] motor_speed   = 8'd0;
   logic       motor_forward = 1'b1;

   drive_result_type pending_drives [$];
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  req_jitter     = 1'b1;   // sender idles at random between words
   bit  rsp_jitter     = 1'b1;   // receiver stalls at random between words
   int  rsp_hold       = 0;      // one long receiver stall, consumed by the ready process

   thermistor_lookup_heater_control i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Table walk plus interpolation, then the bang-bang decision on the
   // current register shadow. Only the low 10 bits of the word count.
   function automatic drive_result_type predict_drive(input logic [15:0] word);
      drive_result_type r;
      int s;
      int t;
      bit found;
      s = int'(word[9:0]);
      t = 0;
      found = 1'b0;
      for (int k = 1; k < 22; k++) begin
         if (!found && knee_adc[k] > s) begin
            // signed divide, truncates toward zero like the hardware
            t = knee_cel[k-1] + ((s - knee_adc[k-1]) * (knee_cel[k] - knee_cel[k-1]))
                / (knee_adc[k] - knee_adc[k-1]);
            found = 1'b1;
         end
      end
      if (t > 255) t = 255;
      if (t < 0) t = 0;
      r.sample_word   = word;
      r.temperature_c = t[7:0];
      if (t < int'(target_temp)) begin
         r.motor_drive  = 8'd0;
         r.heater_drive = heater_power;
      end else begin
         r.motor_drive  = motor_speed;
         r.heater_drive = 8'd0;
      end
      r.direction_out = motor_forward;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want,
                                  input logic [15:0] word);
      $display("mismatch %s: got %0d, expected %0d (sample word 0x%04h)",
               field, got, want, word);
      mismatch_count++;
   endtask

   // one sample word; valid stays high after acceptance so a back-to-back
   // word never sees valid dropped and raised in one step
   task automatic send_sample(input logic [15:0] word);
      int gap;
      gap = req_jitter ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_drives.push_back(predict_drive(word));
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // sender pauses until every result is back
   task automatic wait_results_home();
      stop_sending();
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   // leaves csr_we high; set_registers drops it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_TARGET_TEMP:   target_temp   = value;
         REG_HEATER_POWER:  heater_power  = value;
         REG_MOTOR_SPEED:   motor_speed   = value;
         REG_MOTOR_FORWARD: motor_forward = value[0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [7:0] target, input logic [7:0] heater,
                                input logic [7:0] motor, input logic forward);
      logic [6:0] junk;
      junk = 7'($urandom);
      write_reg(REG_TARGET_TEMP, target);
      write_reg(REG_HEATER_POWER, heater);
      write_reg(REG_MOTOR_SPEED, motor);
      write_reg(REG_MOTOR_FORWARD, {junk, forward});   // upper bits must be ignored
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly inside the table, sometimes anywhere; junk above bit 9 throughout
   function automatic logic [15:0] random_sample();
      logic [15:0] word;
      int pick;
      word = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6)
         word[9:0] = 10'($urandom_range(0, 310));
      else if (pick < 7)
         word[9:0] = 10'($urandom_range(0, 3));
      return word;
   endfunction

   // result side: random stall per word, plus the one long hold when asked
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         gap = rsp_jitter ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[24:0], 0, 16'd0);
         end else begin
            want = pending_drives.pop_front();
            if (rsp_tdata[7:0] !== want.temperature_c)
               report_mismatch("temperature_c", rsp_tdata[7:0], want.temperature_c,
                               want.sample_word);
            if (rsp_tdata[15:8] !== want.motor_drive)
               report_mismatch("motor_drive", rsp_tdata[15:8], want.motor_drive,
                               want.sample_word);
            if (rsp_tdata[23:16] !== want.heater_drive)
               report_mismatch("heater_drive", rsp_tdata[23:16], want.heater_drive,
                               want.sample_word);
            if (rsp_tdata[24] !== want.direction_out)
               report_mismatch("direction_out", rsp_tdata[24], want.direction_out,
                               want.sample_word);
            if (rsp_tdata[31:25] !== 7'd0)
               report_mismatch("padding", rsp_tdata[31:25], 0, want.sample_word);
         end
      end
   end

   // watchdog: ends the run if no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // register values straight out of reset: motor on at speed 0, forward
   task automatic test_reset_defaults();
      send_sample(16'd0);
      send_sample(16'd150);
      send_sample(16'd1023);
      wait_results_home();
   endtask

   // breakpoint edges, extrapolation, clamp, past-table and masked upper bits
   task automatic test_curve_edges();
      logic [15:0] words [20] = '{
         16'd0, 16'd1, 16'd2, 16'd30, 16'd59, 16'd60, 16'd61, 16'd69,
         16'd155, 16'd200, 16'd249, 16'd250, 16'd251, 16'd299, 16'd300, 16'd301,
         16'd512, 16'd1023, 16'hFC96, 16'hFFFF};
      set_registers(8'd100, 8'd200, 8'd150, 1'b0);
      foreach (words[i]) send_sample(words[i]);
      wait_results_home();
   endtask

   // register extremes and thresholds, some of them right on table temperatures
   task automatic test_register_extremes();
      logic [7:0] targets [5] = '{8'd0, 8'd255, 8'd4, 8'd176, 8'd101};
      logic [7:0] heaters [5] = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd170};
      logic [7:0] motors  [5] = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd85};
      logic       fwds    [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      for (int c = 0; c < 5; c++) begin
         set_registers(targets[c], heaters[c], motors[c], fwds[c]);
         repeat (20) send_sample(random_sample());
         wait_results_home();
      end
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure();
      set_registers(8'd120, 8'd77, 8'd33, 1'b1);
      rsp_hold   = 400;
      req_jitter = 1'b0;
      repeat (16) send_sample(random_sample());
      req_jitter = 1'b1;
      wait_results_home();
   endtask

   // bulk random traffic in rounds, registers and idling style vary per round
   task automatic test_random_traffic();
      int mode;
      for (int round = 0; round < 6; round++) begin
         if ($urandom_range(0, 3) == 0)
            set_registers($urandom_range(0, 1) ? 8'd255 : 8'd0,
                          $urandom_range(0, 1) ? 8'd255 : 8'd0,
                          $urandom_range(0, 1) ? 8'd255 : 8'd0, 1'($urandom));
         else
            set_registers(8'($urandom_range(60, 180)), 8'($urandom), 8'($urandom),
                          1'($urandom));
         mode = $urandom_range(0, 3);
         req_jitter = (mode != 0);   // mode 0: no idling at all on either side
         rsp_jitter = (mode != 0) && (mode != 1);
         repeat (55) send_sample(random_sample());
         wait_results_home();
      end
      req_jitter = 1'b1;
      rsp_jitter = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_curve_edges();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      wait_results_home();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_drives.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
src/thl_pkg.sv
src/thl_front.sv
src/thl_queue.sv
src/thl_back.sv
src/thermistor_lookup_heater_control.sv
tb/thermistor_lookup_heater_control_test.sv
